/* hdl/sms_pkg.sv */
// shared types and constants for the spi master shifter
// no dependencies; used by sms_bit_engine and spi_master_shifter
`default_nettype none

package sms_pkg;

	// bits in a narrow (byte) transfer
	localparam int NARROW_BITS = 8;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_BIT_ORDER     = 2'd0,
		REG_SPI_MODE      = 2'd1,
		REG_CLOCK_DIVIDER = 2'd2
	} sms_reg_t;

	// quarters of one bit period; sclk is at idle level in the first two
	typedef enum logic [1:0] {
		QTR_SETUP = 2'd0,
		QTR_DRIVE = 2'd1,
		QTR_LEAD  = 2'd2,
		QTR_TRAIL = 2'd3
	} sms_qtr_t;

	typedef struct packed {
		logic cpol;
		logic cpha;
		logic msb_first;
	} sms_mode_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sms_flags_t;

endpackage

`default_nettype wire

/* hdl/sms_bit_engine.sv */
// next-state logic of the spi shifter for one tick: start latch, quarter
// timing, mosi drive and miso sampling; uses sms_pkg
`default_nettype none

module sms_bit_engine #(
	parameter int MAX_WORD_BITS = 16,
	parameter int DIVIDER_BITS  = 8
) (
	input  sms_pkg::sms_mode_t              mode,
	input  logic [DIVIDER_BITS-1:0]         divider,
	input  logic                            active,
	input  logic                            is_wide,
	input  logic [MAX_WORD_BITS-1:0]        tx_word,
	input  logic [MAX_WORD_BITS-1:0]        rx_word,
	input  logic [$clog2(MAX_WORD_BITS+1)-1:0] bit_count,
	input  sms_pkg::sms_qtr_t               quarter,
	input  logic [DIVIDER_BITS-1:0]         tick_count,
	input  logic                            mosi_level,
	input  logic                            start_req,
	input  logic [MAX_WORD_BITS-1:0]        tx_data,
	input  logic                            wide,
	input  logic                            miso,
	output logic                            active_nxt,
	output logic                            is_wide_nxt,
	output logic [MAX_WORD_BITS-1:0]        tx_word_nxt,
	output logic [MAX_WORD_BITS-1:0]        rx_word_nxt,
	output logic [$clog2(MAX_WORD_BITS+1)-1:0] bit_count_nxt,
	output sms_pkg::sms_qtr_t               quarter_nxt,
	output logic [DIVIDER_BITS-1:0]         tick_count_nxt,
	output logic                            mosi_nxt,
	output logic                            sclk,
	output sms_pkg::sms_flags_t             flags,
	output logic [MAX_WORD_BITS-1:0]        rx_out
);

	localparam int WB  = MAX_WORD_BITS;
	localparam int DB  = DIVIDER_BITS;
	localparam int BCW = $clog2(WB + 1);
	localparam int IW  = $clog2(WB);
	localparam logic [WB-1:0] NARROW_MASK = WB'({sms_pkg::NARROW_BITS{1'b1}});
	localparam logic [BCW-1:0] NARROW_LEN = BCW'(sms_pkg::NARROW_BITS);
	localparam logic [BCW-1:0] WIDE_LEN   = BCW'(WB);

	logic [WB-1:0]  mask;
	logic [BCW-1:0] word_len;
	logic [BCW-1:0] bit_idx;
	logic [DB-1:0]  phase_len;
	logic [DB:0]    tick_inc;
	logic           phase_end;
	logic [WB-1:0]  line_vec;
	logic           do_sample;

	always_comb begin
		active_nxt     = active;
		is_wide_nxt    = is_wide;
		tx_word_nxt    = tx_word;
		rx_word_nxt    = rx_word;
		bit_count_nxt  = bit_count;
		quarter_nxt    = quarter;
		tick_count_nxt = tick_count;
		mosi_nxt       = mosi_level;
		flags          = '0;
		rx_out         = '0;
		do_sample      = 1'b0;

		// start latch happens before the tick is processed
		if (!active && start_req) begin
			active_nxt     = 1'b1;
			is_wide_nxt    = wide;
			tx_word_nxt    = wide ? tx_data : (tx_data & NARROW_MASK);
			rx_word_nxt    = '0;
			bit_count_nxt  = '0;
			quarter_nxt    = sms_pkg::QTR_SETUP;
			tick_count_nxt = '0;
		end

		mask     = is_wide_nxt ? '1 : NARROW_MASK;
		word_len = is_wide_nxt ? WIDE_LEN : NARROW_LEN;

		bit_idx = (bit_count_nxt < word_len) ? bit_count_nxt : (word_len - 1'b1);
		if (mode.msb_first)
			bit_idx = word_len - 1'b1 - bit_idx;
		line_vec = WB'(miso) << (word_len - 1'b1);

		phase_len = divider >> 1;
		if (phase_len == '0)
			phase_len = DB'(1);
		tick_inc  = {1'b0, tick_count_nxt} + 1'b1;
		phase_end = tick_inc >= {1'b0, phase_len};

		sclk = mode.cpol;

		if (active_nxt) begin
			flags.busy = 1'b1;
			if (tick_count_nxt == '0) begin
				if (quarter_nxt == sms_pkg::QTR_DRIVE && !mode.cpha)
					mosi_nxt = tx_word_nxt[bit_idx[IW-1:0]];
				else if (quarter_nxt == sms_pkg::QTR_TRAIL) begin
					if (mode.cpha)
						mosi_nxt = tx_word_nxt[bit_idx[IW-1:0]];
					else
						do_sample = 1'b1;
				end
			end
			if (quarter_nxt == sms_pkg::QTR_LEAD || quarter_nxt == sms_pkg::QTR_TRAIL)
				sclk = ~mode.cpol;
			// cpha=1 samples on the trailing edge, at the end of the last quarter
			if (phase_end && quarter_nxt == sms_pkg::QTR_TRAIL && mode.cpha)
				do_sample = 1'b1;

			if (do_sample) begin
				if (mode.msb_first)
					rx_word_nxt = ((rx_word_nxt << 1) | WB'(miso)) & mask;
				else
					rx_word_nxt = ((rx_word_nxt >> 1) | line_vec) & mask;
			end

			if (phase_end) begin
				tick_count_nxt = '0;
				case (quarter_nxt)
					sms_pkg::QTR_SETUP: quarter_nxt = sms_pkg::QTR_DRIVE;
					sms_pkg::QTR_DRIVE: quarter_nxt = sms_pkg::QTR_LEAD;
					sms_pkg::QTR_LEAD:  quarter_nxt = sms_pkg::QTR_TRAIL;
					default: begin
						quarter_nxt   = sms_pkg::QTR_SETUP;
						bit_count_nxt = bit_count_nxt + 1'b1;
						if (bit_count_nxt >= word_len) begin
							active_nxt    = 1'b0;
							bit_count_nxt = '0;
							flags.done    = 1'b1;
							rx_out        = rx_word_nxt & mask;
						end
					end
				endcase
			end else begin
				tick_count_nxt = tick_inc[DB-1:0];
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/spi_master_shifter.sv */
// top level of the spi master shifter: config registers, shifter state and
// result register; uses sms_pkg and sms_bit_engine
//
// channel  handshake              payload
// in       in_valid / in_ready    start_req, tx_data, wide, miso (one tick)
// out      out_valid / out_ready  sclk, mosi, busy_res, done_res, rx_data
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each request is one tick of the bit timing: the shifter state and the result
// register update on the accepting edge
// a new request is taken every clock unless the result register is full and
// out_ready is low; cfg_ready is always high
// arst_n clears the state and the result valid flag and loads the register defaults
`default_nettype none

module spi_master_shifter #(
	parameter int MAX_WORD_BITS = 16,
	parameter int DIVIDER_BITS  = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     start_req,
	input  logic [MAX_WORD_BITS-1:0] tx_data,
	input  logic                     wide,
	input  logic                     miso,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     sclk,
	output logic                     mosi,
	output logic                     busy_res,
	output logic                     done_res,
	output logic [MAX_WORD_BITS-1:0] rx_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [DIVIDER_BITS-1:0]  cfg_data
);

	localparam int WB  = MAX_WORD_BITS;
	localparam int DB  = DIVIDER_BITS;
	localparam int BCW = $clog2(WB + 1);

	logic           bit_order_q;
	logic [1:0]     spi_mode_q;
	logic [DB-1:0]  divider_q;

	logic              active_q, is_wide_q, mosi_q;
	logic [WB-1:0]     tx_word_q, rx_word_q;
	logic [BCW-1:0]    bit_count_q;
	sms_pkg::sms_qtr_t quarter_q;
	logic [DB-1:0]     tick_count_q;

	logic              active_nxt, is_wide_nxt, mosi_nxt;
	logic [WB-1:0]     tx_word_nxt, rx_word_nxt;
	logic [BCW-1:0]    bit_count_nxt;
	sms_pkg::sms_qtr_t quarter_nxt;
	logic [DB-1:0]     tick_count_nxt;
	logic              sclk_nxt;
	sms_pkg::sms_flags_t flags_nxt;
	logic [WB-1:0]     rx_out_nxt;

	sms_pkg::sms_mode_t mode;
	logic               out_valid_q;
	logic               in_acc;

	assign mode.cpol      = spi_mode_q[1];
	assign mode.cpha      = spi_mode_q[0];
	assign mode.msb_first = bit_order_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_order_q <= 1'b1;
			spi_mode_q  <= 2'd0;
			divider_q   <= DB'(2);
		end else if (cfg_valid) begin
			case (sms_pkg::sms_reg_t'(cfg_index))
				sms_pkg::REG_BIT_ORDER:     bit_order_q <= cfg_data[0];
				sms_pkg::REG_SPI_MODE:      spi_mode_q  <= cfg_data[1:0];
				sms_pkg::REG_CLOCK_DIVIDER: divider_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	sms_bit_engine #(
		.MAX_WORD_BITS(MAX_WORD_BITS),
		.DIVIDER_BITS (DIVIDER_BITS)
	) u_engine (
		.mode          (mode),
		.divider       (divider_q),
		.active        (active_q),
		.is_wide       (is_wide_q),
		.tx_word       (tx_word_q),
		.rx_word       (rx_word_q),
		.bit_count     (bit_count_q),
		.quarter       (quarter_q),
		.tick_count    (tick_count_q),
		.mosi_level    (mosi_q),
		.start_req     (start_req),
		.tx_data       (tx_data),
		.wide          (wide),
		.miso          (miso),
		.active_nxt    (active_nxt),
		.is_wide_nxt   (is_wide_nxt),
		.tx_word_nxt   (tx_word_nxt),
		.rx_word_nxt   (rx_word_nxt),
		.bit_count_nxt (bit_count_nxt),
		.quarter_nxt   (quarter_nxt),
		.tick_count_nxt(tick_count_nxt),
		.mosi_nxt      (mosi_nxt),
		.sclk          (sclk_nxt),
		.flags         (flags_nxt),
		.rx_out        (rx_out_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			is_wide_q    <= 1'b0;
			tx_word_q    <= '0;
			rx_word_q    <= '0;
			bit_count_q  <= '0;
			quarter_q    <= sms_pkg::QTR_SETUP;
			tick_count_q <= '0;
			mosi_q       <= 1'b0;
		end else if (in_acc) begin
			active_q     <= active_nxt;
			is_wide_q    <= is_wide_nxt;
			tx_word_q    <= tx_word_nxt;
			rx_word_q    <= rx_word_nxt;
			bit_count_q  <= bit_count_nxt;
			quarter_q    <= quarter_nxt;
			tick_count_q <= tick_count_nxt;
			mosi_q       <= mosi_nxt;
		end
	end

	// result register; holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_acc)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sclk     <= sclk_nxt;
			mosi     <= mosi_nxt;
			busy_res <= flags_nxt.busy;
			done_res <= flags_nxt.done;
			rx_data  <= rx_out_nxt;
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_res |-> busy_res)
		else $error("done without busy");

	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !done_res |-> rx_data == '0)
		else $error("rx_data nonzero outside done");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> bit_count_q == '0 && tick_count_q == '0 &&
			quarter_q == sms_pkg::QTR_SETUP)
		else $error("counters not cleared while idle");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> bit_count_q < (is_wide_q ? BCW'(WB) : BCW'(sms_pkg::NARROW_BITS)))
		else $error("bit count beyond word length");

	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted request produced no result");

endmodule

`default_nettype wire

/* tb/spi_master_shifter_tb.sv */
// self-checking testbench for spi_master_shifter: per-tick line prediction,
// random idling on both channels and a long receiver hold-off
// depends on sms_pkg and the spi_master_shifter rtl
`timescale 1ns / 1ps

module spi_master_shifter_tb;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_LEN = 300;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic        start_req;
		logic [15:0] tx_data;
		logic        wide;
		logic        miso;
	} tick_t;

	typedef struct packed {
		logic        sclk;
		logic        mosi;
		logic        busy;
		logic        done;
		logic [15:0] rx;
	} line_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        start_req = 1'b0;
	logic [15:0] tx_data = '0;
	logic        wide = 1'b0;
	logic        miso = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        sclk;
	logic        mosi;
	logic        busy_res;
	logic        done_res;
	logic [15:0] rx_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	spi_master_shifter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.start_req (start_req),
		.tx_data   (tx_data),
		.wide      (wide),
		.miso      (miso),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sclk      (sclk),
		.mosi      (mosi),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.rx_data   (rx_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// predicted register and shifter state
	sms_pkg::sms_mode_t cfg_mode = '{cpol: 1'b0, cpha: 1'b0, msb_first: 1'b1};
	logic [7:0]  cfg_div = 8'd2;
	logic        sh_active = 1'b0;
	logic [15:0] sh_tx = '0;
	logic [15:0] sh_rx = '0;
	logic [4:0]  sh_bits = '0;
	sms_pkg::sms_qtr_t sh_qtr = sms_pkg::QTR_SETUP;
	logic [7:0]  sh_ticks = '0;
	logic        sh_wide = 1'b0;
	logic        sh_mosi = 1'b0;

	tick_t tick_q[$];
	line_t pin_lines_q[$];
	tick_t cur_tick;
	line_t cur_line;

	int send_idle_pct = 12;
	int recv_idle_pct = 80;
	int err_count = 0;
	int unsigned cycle_cnt = 0;

	logic hold_req = 1'b0;
	logic holding = 1'b0;
	int   hold_cnt = 0;

	function automatic void put_bit();
		int n;
		int idx;
		n = sh_wide ? 16 : 8;
		idx = (sh_bits < n) ? int'(sh_bits) : n - 1;
		if (cfg_mode.msb_first)
			idx = n - 1 - idx;
		sh_mosi = sh_tx[idx];
	endfunction

	function automatic void take_bit(logic line);
		int n;
		logic [15:0] mask;
		n = sh_wide ? 16 : 8;
		mask = sh_wide ? 16'hFFFF : 16'h00FF;
		if (cfg_mode.msb_first)
			sh_rx = ((sh_rx << 1) | 16'(line)) & mask;
		else
			sh_rx = ((sh_rx >> 1) | (16'(line) << (n - 1))) & mask;
	endfunction

	// one tick of the shifter: advances the predicted state, returns the pin levels
	task automatic spi_tick(input tick_t t, output line_t r);
		logic [7:0] ph;
		int n;
		ph = cfg_div >> 1;
		if (ph == 0)
			ph = 8'd1;
		r = '0;
		r.sclk = cfg_mode.cpol;
		if (!sh_active && t.start_req) begin
			sh_active = 1'b1;
			sh_wide = t.wide;
			sh_tx = t.wide ? t.tx_data : {8'h00, t.tx_data[7:0]};
			sh_rx = '0;
			sh_bits = '0;
			sh_qtr = sms_pkg::QTR_SETUP;
			sh_ticks = '0;
		end
		n = sh_wide ? 16 : 8;
		if (sh_active) begin
			r.busy = 1'b1;
			if (sh_ticks == 0) begin
				if (sh_qtr == sms_pkg::QTR_DRIVE && !cfg_mode.cpha) begin
					put_bit();
				end else if (sh_qtr == sms_pkg::QTR_TRAIL) begin
					if (cfg_mode.cpha)
						put_bit();
					else
						take_bit(t.miso);
				end
			end
			r.sclk = (sh_qtr == sms_pkg::QTR_LEAD || sh_qtr == sms_pkg::QTR_TRAIL)
				? ~cfg_mode.cpol : cfg_mode.cpol;
			sh_ticks = sh_ticks + 8'd1;
			// a shrunken phase length ends the quarter at once
			if (sh_ticks >= ph) begin
				sh_ticks = '0;
				if (sh_qtr == sms_pkg::QTR_TRAIL) begin
					if (cfg_mode.cpha)
						take_bit(t.miso);
					sh_bits = sh_bits + 5'd1;
					sh_qtr = sms_pkg::QTR_SETUP;
					if (sh_bits >= n) begin
						sh_active = 1'b0;
						sh_bits = '0;
						r.done = 1'b1;
						r.rx = sh_rx & (sh_wide ? 16'hFFFF : 16'h00FF);
					end
				end else begin
					sh_qtr = sms_pkg::sms_qtr_t'(sh_qtr + 2'd1);
				end
			end
		end
		r.mosi = sh_mosi;
	endtask

	// driver: offers queued ticks, predicts each accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				spi_tick(cur_tick, cur_line);
				pin_lines_q.push_back(cur_line);
			end
			if (!in_valid || in_ready) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_tick = tick_q.pop_front();
					in_valid <= 1'b1;
					start_req <= cur_tick.start_req;
					tx_data <= cur_tick.tx_data;
					wide <= cur_tick.wide;
					miso <= cur_tick.miso;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with a counted hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			holding <= 1'b0;
			hold_cnt <= 0;
		end else if (holding) begin
			out_ready <= 1'b0;
			if (hold_cnt == HOLD_LEN)
				holding <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else if (hold_req) begin
			holding <= 1'b1;
			hold_cnt <= 0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		line_t got;
		line_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {sclk, mosi, busy_res, done_res, rx_data};
			if (pin_lines_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result: sclk=%b mosi=%b busy=%b done=%b rx=%h",
						got.sclk, got.mosi, got.busy, got.done, got.rx);
			end else begin
				want = pin_lines_q.pop_front();
				if (got !== want) begin
					err_count++;
					if (err_count <= 10) begin
						$display("mismatch: want sclk=%b mosi=%b busy=%b done=%b rx=%h",
							want.sclk, want.mosi, want.busy, want.done, want.rx);
						$display("          got  sclk=%b mosi=%b busy=%b done=%b rx=%h",
							got.sclk, got.mosi, got.busy, got.done, got.rx);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("spi_master_shifter_tb: errors");
			$finish;
		end
	end

	function automatic int xfer_len(logic w);
		int ph;
		ph = cfg_div >> 1;
		if (ph == 0)
			ph = 1;
		return (w ? 16 : 8) * 4 * ph;
	endfunction

	task automatic add_tick(input logic s, input logic [15:0] d, input logic w,
		input logic m);
		tick_q.push_back('{start_req: s, tx_data: d, wide: w, miso: m});
	endtask

	// start request plus body ticks; miso_kind 0 low, 1 high, 2 random
	task automatic add_transfer(input logic [15:0] d, input logic w, input int body,
		input int miso_kind);
		int i;
		logic m;
		add_tick(1'b1, d, w, miso_kind == 2 ? 1'($urandom) : miso_kind == 1);
		for (i = 0; i < body; i++) begin
			m = (miso_kind == 2) ? 1'($urandom) : (miso_kind == 1);
			// start while busy is ignored
			add_tick($urandom_range(9) == 0, 16'($urandom), 1'($urandom), m);
		end
	endtask

	// wait until every request is through and every result has arrived
	task automatic drain();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || in_valid || pin_lines_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_regs(input logic bo, input logic [1:0] mode, input logic [7:0] div);
		logic [1:0] idx [4];
		logic [7:0] val [4];
		int i;
		idx = '{sms_pkg::REG_BIT_ORDER, sms_pkg::REG_SPI_MODE,
			sms_pkg::REG_CLOCK_DIVIDER, REG_UNUSED};
		val = '{{7'($urandom), bo}, {6'($urandom), mode}, div, 8'($urandom)};
		for (i = 0; i < 4; i++) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[i])
				sms_pkg::REG_BIT_ORDER: cfg_mode.msb_first = val[i][0];
				sms_pkg::REG_SPI_MODE: begin
					cfg_mode.cpol = val[i][1];
					cfg_mode.cpha = val[i][0];
				end
				sms_pkg::REG_CLOCK_DIVIDER: cfg_div = val[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int p;
		int body;
		int gap;
		logic w;
		logic [7:0] div;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle line after reset, then the data extremes at the reset settings
		repeat (3) add_tick(1'b0, 16'($urandom), 1'($urandom), 1'($urandom));
		add_transfer(16'hFFFF, 1'b0, xfer_len(1'b0) - 1, 1);
		add_transfer(16'h0000, 1'b1, xfer_len(1'b1) - 1, 1);
		add_transfer(16'hFFFF, 1'b1, xfer_len(1'b1) - 1, 0);
		repeat (3) add_tick(1'b0, 16'($urandom), 1'($urandom), 1'($urandom));
		drain();

		// registers changed in the middle of a transfer, phase length shrinking
		write_regs(1'b0, 2'd3, 8'd8);
		add_transfer(16'h8001, 1'b1, 41, 2);
		drain();
		write_regs(1'b1, 2'd2, 8'd0);
		repeat (60) add_tick(1'b0, 16'($urandom), 1'($urandom), 1'($urandom));
		drain();

		for (p = 0; p < 6; p++) begin
			send_idle_pct = (p < 2) ? 12 : (p < 4) ? 80 : 0;
			recv_idle_pct = (p < 2) ? 80 : (p < 4) ? 12 : 0;
			if (p == 3)
				div = 8'd255;
			else if (p == 0)
				div = 8'd1;
			else
				div = 8'($urandom_range(0, 3));
			write_regs(1'((p / 2 + p) % 2), 2'(p % 4), div);
			w = (p == 5);
			body = xfer_len(w) - 1;
			// slowest divider is cut short, so the next phase length shrinks mid-transfer
			if (div >= 8'd128)
				body = 40;
			else if ($urandom_range(7) == 0)
				body = $urandom_range(body);
			add_transfer(16'($urandom), w, body, 2);
			gap = $urandom_range(0, 4);
			repeat (gap) add_tick(1'b0, 16'($urandom), 1'($urandom), 1'($urandom));
			if (p == 4) begin
				hold_req = 1'b1;
				while (!holding)
					@(posedge clk);
				hold_req = 1'b0;
			end
			drain();
		end

		if (err_count == 0)
			$display("spi_master_shifter_tb: clean");
		else
			$display("spi_master_shifter_tb: errors");
		$finish;
	end

endmodule

/* sim.f */
hdl/sms_pkg.sv
hdl/sms_bit_engine.sv
hdl/spi_master_shifter.sv
tb/spi_master_shifter_tb.sv
